FILE: rtl/fatlb_pkg.sv
package fatlb_pkg;

    localparam int ENTRIES   = 16;
    localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int PAGE_W    = 20;
    localparam int FRAME_W   = 20;
    localparam int STAMP_W   = 64;
    localparam int OP_W      = 2;
    localparam int COUNT_W   = 5;
    localparam int COUNT_MAX = 31;
    // wide enough for the full population count and for the saturation limit
    localparam int POP_W     = ($clog2(ENTRIES + 1) > COUNT_W) ? $clog2(ENTRIES + 1) : COUNT_W;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 2'd0,
        OP_UPDATE = 2'd1,
        OP_FLUSH  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_VICT,
        S_SCAN,
        S_WRITE,
        S_FLUSH,
        S_COUNT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic clk_inc;
        logic look;
        logic vict_init;
        logic scan;
        logic write;
        logic flush;
        logic count;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] in_op;
        logic            scan_needed;
        logic            scan_last;
        logic            out_free;
    } t_sts;

endpackage

FILE: rtl/fatlb_ctrl.sv
module fatlb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  fatlb_pkg::t_sts i_sts,
    output logic            o_in_ready,
    output fatlb_pkg::t_cmd o_cmd
);

    fatlb_pkg::t_state r_state;
    fatlb_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fatlb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            fatlb_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    case (i_sts.in_op)
                        fatlb_pkg::OP_LOOKUP: n_state = fatlb_pkg::S_LOOK;
                        fatlb_pkg::OP_UPDATE: n_state = fatlb_pkg::S_VICT;
                        fatlb_pkg::OP_FLUSH:  n_state = fatlb_pkg::S_FLUSH;
                        default:              n_state = fatlb_pkg::S_DONE;
                    endcase
                end
            end
            fatlb_pkg::S_LOOK:  n_state = fatlb_pkg::S_DONE;
            fatlb_pkg::S_VICT: begin
                n_state = i_sts.scan_needed ? fatlb_pkg::S_SCAN : fatlb_pkg::S_WRITE;
            end
            fatlb_pkg::S_SCAN: begin
                if (i_sts.scan_last) begin
                    n_state = fatlb_pkg::S_WRITE;
                end
            end
            fatlb_pkg::S_WRITE: n_state = fatlb_pkg::S_DONE;
            fatlb_pkg::S_FLUSH: n_state = fatlb_pkg::S_COUNT;
            fatlb_pkg::S_COUNT: n_state = fatlb_pkg::S_DONE;
            fatlb_pkg::S_DONE: begin
                if (i_sts.out_free) begin
                    n_state = fatlb_pkg::S_IDLE;
                end
            end
            default: n_state = fatlb_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            fatlb_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.capture  = i_in_valid;
            end
            fatlb_pkg::S_LOOK: begin
                o_cmd.clk_inc = 1'b1;
                o_cmd.look    = 1'b1;
            end
            fatlb_pkg::S_VICT: begin
                o_cmd.clk_inc   = 1'b1;
                o_cmd.vict_init = 1'b1;
            end
            fatlb_pkg::S_SCAN:  o_cmd.scan     = 1'b1;
            fatlb_pkg::S_WRITE: o_cmd.write    = 1'b1;
            fatlb_pkg::S_FLUSH: o_cmd.flush    = 1'b1;
            fatlb_pkg::S_COUNT: o_cmd.count    = 1'b1;
            fatlb_pkg::S_DONE:  o_cmd.load_out = i_sts.out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/fatlb_dp.sv
module fatlb_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fatlb_pkg::t_cmd                     i_cmd,
    input  logic [fatlb_pkg::OP_W-1:0]          i_in_op,
    input  logic [fatlb_pkg::IN_DATA_W-1:0]     i_in_data,
    input  logic                                i_out_ready,
    output fatlb_pkg::t_sts                     o_sts,
    output logic                                o_out_valid,
    output logic [fatlb_pkg::OUT_DATA_W-1:0]    o_out_data
);

    localparam int PW = fatlb_pkg::PAGE_W;
    localparam int FW = fatlb_pkg::FRAME_W;
    localparam int SW = fatlb_pkg::STAMP_W;
    localparam int IW = fatlb_pkg::IDX_W;
    localparam int N  = fatlb_pkg::ENTRIES;

    // entry store
    logic [N-1:0]  r_valid;
    logic [PW-1:0] r_ent_page  [N];
    logic [FW-1:0] r_ent_frame [N];
    logic [SW-1:0] r_ent_stamp [N];
    logic [SW-1:0] r_clock;
    logic [SW-1:0] n_clock;

    // request and working registers
    logic [PW-1:0] r_req_page;
    logic [FW-1:0] r_req_frame;
    logic [IW-1:0] r_vict;
    logic [IW-1:0] r_scan;
    logic [SW-1:0] r_best;

    // result and output stage
    logic                          r_hit;
    logic [FW-1:0]                 r_frm;
    logic                          r_evv;
    logic [PW-1:0]                 r_evp;
    logic [fatlb_pkg::COUNT_W-1:0] r_cnt;
    logic                          r_out_valid;
    logic [fatlb_pkg::OUT_DATA_W-1:0] r_out_data;

    logic [N-1:0]                  match;
    logic                          any_match;
    logic [IW-1:0]                 match_idx;
    logic [IW-1:0]                 free_idx;
    logic                          all_valid;
    logic [fatlb_pkg::POP_W-1:0]   pop;
    logic [fatlb_pkg::COUNT_W-1:0] pop_sat;
    logic                          out_free;

    assign n_clock = r_clock + SW'(1);

    always_comb begin
        match     = '0;
        match_idx = '0;
        free_idx  = '0;
        pop       = '0;
        for (int i = N - 1; i >= 0; i--) begin
            match[i] = r_valid[i] && (r_ent_page[i] == r_req_page);
            if (match[i]) begin
                match_idx = IW'(i);
            end
            if (!r_valid[i]) begin
                free_idx = IW'(i);
            end
        end
        for (int i = 0; i < N; i++) begin
            pop = pop + fatlb_pkg::POP_W'(r_valid[i]);
        end
    end

    assign any_match = |match;
    assign all_valid = &r_valid;
    assign pop_sat   = (pop > fatlb_pkg::POP_W'(fatlb_pkg::COUNT_MAX))
                       ? fatlb_pkg::COUNT_W'(fatlb_pkg::COUNT_MAX)
                       : pop[fatlb_pkg::COUNT_W-1:0];
    assign out_free  = !r_out_valid || i_out_ready;

    assign o_sts.in_op       = i_in_op;
    assign o_sts.scan_needed = all_valid && (N > 1);
    assign o_sts.scan_last   = (r_scan == IW'(N - 1));
    assign o_sts.out_free    = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= '0;
            r_clock     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clk_inc) begin
                r_clock <= n_clock;
            end
            if (i_cmd.write) begin
                r_valid[r_vict] <= 1'b1;
            end else if (i_cmd.flush) begin
                r_valid <= r_valid & ~match;
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req_page  <= i_in_data[PW-1:0];
            r_req_frame <= i_in_data[PW+FW-1:PW];
            r_hit       <= 1'b0;
            r_frm       <= '0;
            r_evv       <= 1'b0;
            r_evp       <= '0;
            r_cnt       <= '0;
        end
        if (i_cmd.look && any_match) begin
            r_ent_stamp[match_idx] <= n_clock;
            r_hit                  <= 1'b1;
            r_frm                  <= r_ent_frame[match_idx];
        end
        if (i_cmd.vict_init) begin
            r_scan <= IW'(1);
            r_best <= r_ent_stamp[0];
            r_vict <= all_valid ? '0 : free_idx;
        end
        if (i_cmd.scan) begin
            // strict compare keeps the lowest index among equal stamps
            if (r_ent_stamp[r_scan] < r_best) begin
                r_vict <= r_scan;
                r_best <= r_ent_stamp[r_scan];
            end
            r_scan <= r_scan + IW'(1);
        end
        if (i_cmd.write) begin
            if (r_valid[r_vict]) begin
                r_evv <= 1'b1;
                r_evp <= r_ent_page[r_vict];
            end
            r_ent_page[r_vict]  <= r_req_page;
            r_ent_frame[r_vict] <= r_req_frame;
            r_ent_stamp[r_vict] <= r_clock;
        end
        if (i_cmd.count) begin
            r_cnt <= pop_sat;
        end
        if (i_cmd.load_out) begin
            r_out_data <= {1'b0, r_cnt, r_evp, r_evv, r_frm, r_hit};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: rtl/fully_associative_tlb_lru_unit.sv
// Fully associative translation buffer with least-recently-used replacement.
// Requests arrive on the slave stream: tuser carries the opcode (lookup,
// update or flush page), tdata the page and the frame to insert. Each request
// yields exactly one result transfer on the master stream carrying hit,
// frame, evicted flag and page, and the count of entries left after a flush.
// One request is worked on at a time; s_axis_tready is high only while the
// controller is idle. A lookup does a parallel page compare; a flush
// invalidates the matching entry, then counts the valid entries; an update
// takes a free entry or, in a full buffer, finds the least recently used
// entry by a scan of one stamp per cycle, then writes. The controller
// returns to idle as the result is loaded into the output register, so the
// next request can be taken while the result still waits there. When the
// receiver stalls, the result holds in the output register and a following
// request completes its work but waits before the output.
// Reset clears every valid bit, the access clock and the output valid flag.
module fully_associative_tlb_lru_unit (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    // page [19:0], frame_in [39:20]
    input  logic [fatlb_pkg::IN_DATA_W-1:0]       i_s_axis_tdata,
    // opcode [1:0]
    input  logic [fatlb_pkg::OP_W-1:0]            i_s_axis_tuser,
    output logic                                  o_m_axis_tvalid,
    input  logic                                  i_m_axis_tready,
    // hit [0], frame_out [20:1], evicted_valid [21], evicted_page [41:22],
    // valid_count [46:42], zero [47]
    output logic [fatlb_pkg::OUT_DATA_W-1:0]      o_m_axis_tdata
);

    fatlb_pkg::t_cmd cmd;
    fatlb_pkg::t_sts sts;

    fatlb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_sts      (sts),
        .o_in_ready (o_s_axis_tready),
        .o_cmd      (cmd)
    );

    fatlb_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_op     (i_s_axis_tuser),
        .i_in_data   (i_s_axis_tdata),
        .i_out_ready (i_m_axis_tready),
        .o_sts       (sts),
        .o_out_valid (o_m_axis_tvalid),
        .o_out_data  (o_m_axis_tdata)
    );

endmodule
